/* rtl/assert_macros.svh */
// assertion macros used by the port checker in srwf_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SRWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SRWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/srwf_pkg.sv */
// shared types and constants for the replay window filter
// no dependencies
package srwf_pkg;

    localparam int CHANNEL_W          = 4;
    localparam int SEQ_W              = 32;
    localparam int COUNT_W            = 32;
    localparam int VERDICT_W          = 3;
    localparam int DEF_NUM_CHANNELS   = 4;
    localparam int DEF_WINDOW_BITS    = 32;
    localparam int DEF_QUEUE_DEPTH    = 4;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPTED  = 3'd0,
        VERDICT_INVALID   = 3'd1,
        VERDICT_EXACT_DUP = 3'd2,
        VERDICT_TOO_OLD   = 3'd3,
        VERDICT_SEEN      = 3'd4
    } t_verdict;

    // classified transaction handed from front to back
    typedef struct packed {
        logic                 invalid;
        logic [CHANNEL_W-1:0] channel;
        logic [SEQ_W-1:0]     seq;
    } t_item;

endpackage

/* rtl/sequence_replay_window_filter.sv */
// top level of the sliding window replay filter
// depends on srwf_pkg, srwf_front, srwf_queue, srwf_back
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_channel, i_sequence_req
//  out     | o_out_valid | i_out_stall | o_accepted, o_verdict, o_filtered_count
//
// one transaction per cycle while the output does not stall; the window check and
// state update for a channel happen together in the back stage, so consecutive hits
// on a channel never stall; an input passes the front, queue and output registers
// reset clears window state, count and queue; no clearing pass
// output stall fills the queue first, then the input stalls
module sequence_replay_window_filter import srwf_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int WINDOW_BITS  = DEF_WINDOW_BITS,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHANNEL_W-1:0] i_channel,
    input  logic [SEQ_W-1:0]     i_sequence_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_accepted,
    output logic [VERDICT_W-1:0] o_verdict,
    output logic [COUNT_W-1:0]   o_filtered_count
);

    logic  push;
    t_item push_item;
    logic  full;
    logic  head_valid;
    t_item head;
    logic  pop;

    srwf_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_channel      (i_channel),
        .i_sequence_req (i_sequence_req),
        .o_push         (push),
        .o_item         (push_item),
        .i_full         (full)
    );

    srwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    srwf_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .WINDOW_BITS  (WINDOW_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_accepted       (o_accepted),
        .o_verdict        (o_verdict),
        .o_filtered_count (o_filtered_count)
    );

endmodule

/* rtl/srwf_front.sv */
// front stage: takes input transactions and flags invalid ones
// depends on srwf_pkg
module srwf_front import srwf_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHANNEL_W-1:0] i_channel,
    input  logic [SEQ_W-1:0]     i_sequence_req,
    output logic                 o_push,
    output t_item                o_item,
    input  logic                 i_full
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  take;

    assign o_in_stall = r_valid && i_full;
    assign take       = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.invalid <= ({1'b0, i_channel} >= (CHANNEL_W+1)'(NUM_CHANNELS))
                              || (i_sequence_req == '0);
            r_item.channel <= i_channel;
            r_item.seq     <= i_sequence_req;
        end
    end

endmodule

/* rtl/srwf_queue.sv */
// short queue of classified transactions between front and back
// depends on srwf_pkg
module srwf_queue import srwf_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_head_valid,
    output t_item o_head,
    input  logic  i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/srwf_back.sv */
// back stage: per-channel window state, verdict and output register
// depends on srwf_pkg
module srwf_back import srwf_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int WINDOW_BITS  = DEF_WINDOW_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  t_item              i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output logic [VERDICT_W-1:0] o_verdict,
    output logic [COUNT_W-1:0] o_filtered_count
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SH_W  = $clog2(WINDOW_BITS + 1);

    logic [SEQ_W-1:0]       r_high [NUM_CHANNELS];
    logic [WINDOW_BITS-1:0] r_bmp  [NUM_CHANNELS];
    logic [COUNT_W-1:0]     r_total;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_verdict               r_out_verdict;
    logic [COUNT_W-1:0]     r_out_total;

    logic [IDX_W-1:0]       idx;
    logic [SEQ_W-1:0]       top;
    logic [WINDOW_BITS-1:0] bm;
    logic [SEQ_W-1:0]       dist_up;
    logic [SEQ_W-1:0]       dist_dn;
    logic [SH_W-1:0]        sh_up;
    logic [SH_W-1:0]        sh_dn;
    logic [WINDOW_BITS-1:0] bit_up;
    logic [WINDOW_BITS-1:0] bit_dn;
    t_verdict               verdict;
    logic                   wr_state;
    logic [SEQ_W-1:0]       new_high;
    logic [WINDOW_BITS-1:0] new_bm;
    logic                   count_it;
    logic [COUNT_W-1:0]     n_total;

    assign o_pop = i_head_valid && (!r_out_valid || !i_out_stall);

    assign idx     = i_head.channel[IDX_W-1:0];
    assign top     = r_high[idx];
    assign bm      = r_bmp[idx];
    assign dist_up = i_head.seq - top;
    assign dist_dn = top - i_head.seq;
    assign sh_up   = dist_up[SH_W-1:0];
    assign sh_dn   = dist_dn[SH_W-1:0];
    // one-hot for the sequence dist below the (old or current) highest
    assign bit_up  = WINDOW_BITS'(1) << (sh_up - SH_W'(1));
    assign bit_dn  = WINDOW_BITS'(1) << (sh_dn - SH_W'(1));

    always_comb begin
        verdict  = VERDICT_ACCEPTED;
        wr_state = 1'b0;
        new_high = top;
        new_bm   = bm;
        count_it = 1'b0;
        priority if (i_head.invalid) begin
            verdict = VERDICT_INVALID;
        end else if (top == '0) begin
            wr_state = 1'b1;
            new_high = i_head.seq;
            new_bm   = '0;
        end else if (i_head.seq == top) begin
            verdict  = VERDICT_EXACT_DUP;
            count_it = 1'b1;
        end else if (i_head.seq > top) begin
            wr_state = 1'b1;
            new_high = i_head.seq;
            // a jump of the full window shifts every old bit out
            if (dist_up <= SEQ_W'(WINDOW_BITS)) begin
                new_bm = (bm << sh_up) | bit_up;
            end else begin
                new_bm = '0;
            end
        end else if (dist_dn > SEQ_W'(WINDOW_BITS)) begin
            verdict  = VERDICT_TOO_OLD;
            count_it = 1'b1;
        end else if ((bm & bit_dn) != '0) begin
            verdict  = VERDICT_SEEN;
            count_it = 1'b1;
        end else begin
            wr_state = 1'b1;
            new_bm   = bm | bit_dn;
        end
    end

    assign n_total = r_total + COUNT_W'(count_it);

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_high[i] <= '0;
                r_bmp[i]  <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_total <= n_total;
                if (wr_state) begin
                    r_high[idx] <= new_high;
                    r_bmp[idx]  <= new_bm;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_verdict <= verdict;
            r_out_total   <= n_total;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = (r_out_verdict == VERDICT_ACCEPTED);
    assign o_verdict        = r_out_verdict;
    assign o_filtered_count = r_out_total;

endmodule

/* rtl/srwf_checker.sv */
// port-level checks for the replay window filter, bound to the top level
// depends on srwf_pkg and assert_macros.svh
`include "assert_macros.svh"

module srwf_checker import srwf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [CHANNEL_W-1:0] i_channel,
    input logic [SEQ_W-1:0]     i_sequence_req,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_accepted,
    input logic [VERDICT_W-1:0] o_verdict,
    input logic [COUNT_W-1:0]   o_filtered_count
);

    logic out_take;
    logic counted;
    logic passed;

    assign out_take = o_out_valid && !i_out_stall;
    assign counted  = (o_verdict == VERDICT_EXACT_DUP) || (o_verdict == VERDICT_TOO_OLD)
                      || (o_verdict == VERDICT_SEEN);
    assign passed   = (o_verdict == VERDICT_ACCEPTED) || (o_verdict == VERDICT_INVALID);

    `SRWF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_channel) && $stable(i_sequence_req), "input transaction changed while stalled")

    `SRWF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_verdict) && $stable(o_filtered_count), "output transaction changed while stalled")

    `SRWF_ASSERT_NOW(a_accept_flag, i_clk, i_rst_n, o_out_valid, o_accepted == (o_verdict == VERDICT_ACCEPTED), "accepted flag disagrees with verdict")

    `SRWF_ASSERT_NOW(a_count_step, i_clk, i_rst_n, (out_take ##1 (o_out_valid && counted)), o_filtered_count == $past(o_filtered_count) + COUNT_W'(1), "filtered count did not step by one")

    `SRWF_ASSERT_NOW(a_count_hold, i_clk, i_rst_n, (out_take ##1 (o_out_valid && passed)), o_filtered_count == $past(o_filtered_count), "filtered count moved on a passed transaction")

endmodule

bind sequence_replay_window_filter srwf_checker u_srwf_checker (.*);

/* bench/srwf_replay_checker.sv */
`timescale 1ns / 1ps
// checker for the replay window filter: watches both channels, predicts each verdict
// and compares it with the block's result; depends on srwf_pkg
module srwf_replay_checker import srwf_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int WINDOW_BITS  = DEF_WINDOW_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CHANNEL_W-1:0] i_channel,
    input  logic [SEQ_W-1:0]     i_sequence_req,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_accepted,
    input  logic [VERDICT_W-1:0] i_verdict,
    input  logic [COUNT_W-1:0]   i_filtered_count,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               accepted;
        t_verdict           verdict;
        logic [COUNT_W-1:0] filtered;
    } t_outcome;

    logic [SEQ_W-1:0]       win_top [NUM_CHANNELS];
    logic [WINDOW_BITS-1:0] win_map [NUM_CHANNELS];
    logic [COUNT_W-1:0]     filtered_total;
    t_outcome               outcome_q [$];
    t_outcome               want;
    t_verdict               ruling;

    // screens one packet against its channel window and updates the window
    function automatic t_verdict screen_packet(logic [CHANNEL_W-1:0] ch,
                                               logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] top_seq;
        logic [SEQ_W-1:0] gap;
        if (ch >= NUM_CHANNELS || seq == '0) return VERDICT_INVALID;
        top_seq = win_top[ch];
        if (top_seq == '0) begin
            win_top[ch] = seq;
            win_map[ch] = '0;
            return VERDICT_ACCEPTED;
        end
        if (seq == top_seq) begin
            filtered_total = filtered_total + 1'b1;
            return VERDICT_EXACT_DUP;
        end
        if (seq > top_seq) begin
            gap = seq - top_seq;
            if (gap <= WINDOW_BITS) begin
                // a jump of the full window shifts the old map out completely
                win_map[ch] = (gap == WINDOW_BITS) ? '0 : (win_map[ch] << gap);
                win_map[ch][gap-1] = 1'b1;
            end else begin
                win_map[ch] = '0;
            end
            win_top[ch] = seq;
            return VERDICT_ACCEPTED;
        end
        gap = top_seq - seq;
        if (gap > WINDOW_BITS) begin
            filtered_total = filtered_total + 1'b1;
            return VERDICT_TOO_OLD;
        end
        if (win_map[ch][gap-1]) begin
            filtered_total = filtered_total + 1'b1;
            return VERDICT_SEEN;
        end
        win_map[ch][gap-1] = 1'b1;
        return VERDICT_ACCEPTED;
    endfunction

    task automatic flag_mismatch(input string field, input logic [COUNT_W-1:0] want_val,
                                 input logic [COUNT_W-1:0] got_val);
        if (o_mismatches < REPORT_LIMIT)
            $display("mismatch on %s at %0t ns: expected %0h, got %0h",
                     field, $time, want_val, got_val);
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                win_top[c] = '0;
                win_map[c] = '0;
            end
            filtered_total = '0;
            o_mismatches   = 0;
            outcome_q.delete();
        end else begin
            // results first, so a result can never match a transaction of the same edge
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    flag_mismatch("result with no transaction pending, verdict", '0,
                                  i_verdict);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_accepted !== want.accepted)
                        flag_mismatch("accepted", want.accepted, i_accepted);
                    if (i_verdict !== want.verdict)
                        flag_mismatch("verdict", want.verdict, i_verdict);
                    if (i_filtered_count !== want.filtered)
                        flag_mismatch("filtered_count", want.filtered,
                                      i_filtered_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ruling = screen_packet(i_channel, i_sequence_req);
                want.accepted = (ruling == VERDICT_ACCEPTED);
                want.verdict  = ruling;
                want.filtered = filtered_total;
                outcome_q.push_back(want);
            end
        end
        o_outstanding = outcome_q.size();
    end

endmodule

/* bench/sequence_replay_window_filter_tb.sv */
`timescale 1ns / 1ps
// top of the replay window filter bench: clock, reset, packet stimulus and verdict
// depends on srwf_pkg, the filter rtl and srwf_replay_checker
module sequence_replay_window_filter_tb;
    import srwf_pkg::*;

    localparam int NUM_CH         = DEF_NUM_CHANNELS;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CHANNEL_W-1:0] in_channel;
    logic [SEQ_W-1:0]     in_seq;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 out_accepted;
    logic [VERDICT_W-1:0] out_verdict;
    logic [COUNT_W-1:0]   out_filtered;

    int                   mismatches;
    int                   outstanding;
    int                   send_idle_pct;
    int                   recv_stall_pct = 0;
    logic                 hold_req = 1'b0;
    int                   hold_left = 0;
    int                   idle_cycles = 0;
    logic [SEQ_W-1:0]     lead_seq [NUM_CH];

    sequence_replay_window_filter i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_channel        (in_channel),
        .i_sequence_req   (in_seq),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_accepted       (out_accepted),
        .o_verdict        (out_verdict),
        .o_filtered_count (out_filtered)
    );

    srwf_replay_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_channel        (in_channel),
        .i_sequence_req   (in_seq),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_accepted       (out_accepted),
        .i_verdict        (out_verdict),
        .i_filtered_count (out_filtered),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_req  <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ends the run when neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL sequence_replay_window_filter");
            $finish;
        end
    end

    // offers one packet from a falling edge and returns at the falling edge after acceptance
    task automatic offer_packet(input logic [CHANNEL_W-1:0] ch, input logic [SEQ_W-1:0] seq);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_channel <= ch;
        in_seq     <= seq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (ch < NUM_CH && seq != '0 && (lead_seq[ch] == '0 || seq > lead_seq[ch]))
            lead_seq[ch] = seq;
    endtask

    // mostly packets placed around the channel's leading sequence, some noise
    task automatic offer_random_packet();
        logic [CHANNEL_W-1:0] ch;
        logic [SEQ_W-1:0]     lead;
        logic [SEQ_W-1:0]     seq;
        int                   pick;
        if ($urandom_range(99) < 8)
            ch = CHANNEL_W'($urandom_range(15));
        else
            ch = CHANNEL_W'($urandom_range(NUM_CH - 1));
        lead = (ch < NUM_CH) ? lead_seq[ch] : $urandom();
        pick = $urandom_range(99);
        if (pick < 3)
            seq = '0;
        else if (pick < 8)
            seq = $urandom();
        else if (pick < 28)
            seq = lead + $urandom_range(31, 1);
        else if (pick < 33)
            seq = lead + 32;
        else if (pick < 38)
            seq = lead + $urandom_range(5000, 33);
        else if (pick < 48)
            seq = lead;
        else if (pick < 80)
            seq = lead - $urandom_range(32, 1);
        else if (pick < 90)
            seq = lead - $urandom_range(100, 33);
        else
            seq = lead - $urandom_range(40, 28);
        offer_packet(ch, seq);
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_channel    = '0;
        in_seq        = '0;
        send_idle_pct = 0;
        for (int c = 0; c < NUM_CH; c++) lead_seq[c] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // invalid packets: sequence zero, channel out of range
        offer_packet(0, 0);
        offer_packet(4, 7);
        offer_packet(15, 32'hFFFF_FFFF);
        // empty channel start, exact duplicate, in-window new and seen
        offer_packet(0, 100);
        offer_packet(0, 100);
        offer_packet(0, 101);
        offer_packet(0, 99);
        offer_packet(0, 99);
        // jump of exactly the window, then the window edge and one past it
        offer_packet(0, 133);
        offer_packet(0, 101);
        offer_packet(0, 100);
        // jump beyond the window clears the map
        offer_packet(0, 200);
        offer_packet(0, 168);
        offer_packet(0, 167);
        // sequence extremes
        offer_packet(1, 32'hFFFF_FFFF);
        offer_packet(1, 1);
        offer_packet(1, 32'hFFFF_FFFE);
        offer_packet(2, 1);
        offer_packet(2, 32'hFFFF_FFFF);
        // jump just under the window
        offer_packet(3, 5);
        offer_packet(3, 36);
        offer_packet(3, 5);
        offer_packet(3, 4);
        offer_packet(3, 0);

        send_idle_pct = 30;
        recv_stall_pct <= 86;
        repeat (360) offer_random_packet();

        send_idle_pct = 86;
        recv_stall_pct <= 30;
        repeat (360) offer_random_packet();

        send_idle_pct = 0;
        recv_stall_pct <= 0;
        repeat (100) offer_random_packet();
        // long receiver hold-off while packets keep coming, so the input backs up
        hold_req <= 1'b1;
        repeat (150) offer_random_packet();
        // sender pauses until every result is back
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (130) offer_random_packet();

        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS sequence_replay_window_filter");
        else
            $display("FAIL sequence_replay_window_filter");
        $finish;
    end

endmodule
